// ===== rtl/core/quaternion_vector_rotate_defines.svh =====
// Assertion macros shared by the quaternion rotation RTL.
// Each macro samples on the rising edge of i_clk.
`ifndef QUATERNION_VECTOR_ROTATE_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATE_DEFINES_SVH

// Checked only while the block is out of reset.
`define QVR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, during reset too.
`define QVR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/core/qvr_pkg.sv =====
`default_nettype none

package qvr_pkg;

    // Default field format: Q2.14 in 16 bits.
    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT_W = 2'd0,
        CFG_ROT_X = 2'd1,
        CFG_ROT_Y = 2'd2,
        CFG_ROT_Z = 2'd3
    } t_cfg_reg;

endpackage

`default_nettype wire

// ===== rtl/core/qvr_vec_if.sv =====
`default_nettype none

// Input channel: one vector per item.
interface qvr_vec_if #(
    parameter int DATA_WIDTH = qvr_pkg::DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] vec_x;
    logic signed [DATA_WIDTH-1:0] vec_y;
    logic signed [DATA_WIDTH-1:0] vec_z;

    modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
    modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/qvr_res_if.sv =====
`default_nettype none

// Result channel: one rotated vector per item.
interface qvr_res_if #(
    parameter int DATA_WIDTH = qvr_pkg::DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] out_x;
    logic signed [DATA_WIDTH-1:0] out_y;
    logic signed [DATA_WIDTH-1:0] out_z;

    modport source (output valid, output out_x, output out_y, output out_z, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/quaternion_vector_rotate.sv =====
// Rotates a stream of 3-D vectors by the quaternion q held in four registers.
// Each item on i_vec carries vec_x/vec_y/vec_z; each item on o_res carries the
// rotated out_x/out_y/out_z, signed fixed point with FRAC_BITS fraction bits.
// The result is q * (0, v) * conj(q), rounded half up and saturated; q is not
// normalized, so a non-unit q scales the vector by |q|^2.
// The rotation is written through i_cfg_we/i_cfg_idx/i_cfg_data, index 0 to 3
// for w, x, y, z. The user must write it only while no item is in flight;
// the block itself does not enforce this. The four stages are:
// twelve products v*q, sum and saturation of p*conj(q), twelve products q*t,
// and the final sum and saturation into the output register.
// Throughput is one item per cycle when not stalled; each stage moves on
// whenever the stage after it is empty or moving, so bubbles close up under a
// stall. When the receiver stalls, the output register holds its item and the
// stages behind it fill; i_vec.ready drops only when all four stages are full.
// A synchronous reset empties the pipeline and sets q to identity (1, 0, 0, 0).
`default_nettype none
`include "quaternion_vector_rotate_defines.svh"

module quaternion_vector_rotate #(
    parameter int DATA_WIDTH = qvr_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = qvr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    qvr_vec_if.sink                           i_vec,
    qvr_res_if.source                         o_res,
    input  wire logic                         i_cfg_we,
    input  wire logic [qvr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [DATA_WIDTH-1:0]        i_cfg_data
);

    localparam int DW  = DATA_WIDTH;
    localparam int TW  = DW + 2;        // stage-two result width
    localparam int P1W = 2 * DW;        // v * q product
    localparam int A1W = 2 * DW + 2;    // sum of three products plus rounding
    localparam int P2W = 2 * DW + 2;    // q * t product
    localparam int A2W = 2 * DW + 4;    // sum of four products plus rounding
    localparam int NSTG = 4;

    localparam logic signed [A1W-1:0] RND1 = A1W'(1) << (FRAC_BITS - 1);
    localparam logic signed [A2W-1:0] RND2 = A2W'(1) << (FRAC_BITS - 1);
    localparam logic [DW-1:0] ROT_ONE = DW'(1) << FRAC_BITS;

    // Rotation quaternion registers.
    logic signed [DW-1:0] r_rot_w, r_rot_x, r_rot_y, r_rot_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_w <= ROT_ONE;
            r_rot_x <= '0;
            r_rot_y <= '0;
            r_rot_z <= '0;
        end else if (i_cfg_we) begin
            unique case (qvr_pkg::t_cfg_reg'(i_cfg_idx))
                qvr_pkg::CFG_ROT_W: r_rot_w <= i_cfg_data;
                qvr_pkg::CFG_ROT_X: r_rot_x <= i_cfg_data;
                qvr_pkg::CFG_ROT_Y: r_rot_y <= i_cfg_data;
                qvr_pkg::CFG_ROT_Z: r_rot_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage valid bits and per-stage load enables. A stage loads when it is
    // empty or when its item moves on into the next stage in the same cycle.
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] stg_en;

    always_comb begin
        stg_en[NSTG-1] = !r_vld[NSTG-1] || o_res.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            stg_en[k] = !r_vld[k] || stg_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_en[0]) begin
                r_vld[0] <= i_vec.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (stg_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign i_vec.ready = stg_en[0];

    // Stage 1: the twelve products of p * conj(q), rows t_w, t_x, t_y, t_z.
    logic signed [P1W-1:0] r_p1 [4][3];
    logic signed [P1W-1:0] n_p1 [4][3];

    always_comb begin
        n_p1[0][0] = P1W'(i_vec.vec_x) * P1W'(r_rot_x);
        n_p1[0][1] = P1W'(i_vec.vec_y) * P1W'(r_rot_y);
        n_p1[0][2] = P1W'(i_vec.vec_z) * P1W'(r_rot_z);
        n_p1[1][0] = P1W'(i_vec.vec_x) * P1W'(r_rot_w);
        n_p1[1][1] = P1W'(i_vec.vec_y) * P1W'(r_rot_z);
        n_p1[1][2] = P1W'(i_vec.vec_z) * P1W'(r_rot_y);
        n_p1[2][0] = P1W'(i_vec.vec_x) * P1W'(r_rot_z);
        n_p1[2][1] = P1W'(i_vec.vec_y) * P1W'(r_rot_w);
        n_p1[2][2] = P1W'(i_vec.vec_z) * P1W'(r_rot_x);
        n_p1[3][0] = P1W'(i_vec.vec_y) * P1W'(r_rot_x);
        n_p1[3][1] = P1W'(i_vec.vec_z) * P1W'(r_rot_w);
        n_p1[3][2] = P1W'(i_vec.vec_x) * P1W'(r_rot_y);
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r_p1 <= n_p1;
        end
    end

    // Stage 2: sum each row, round to FRAC_BITS and saturate to DW+2 bits.
    logic signed [A1W-1:0] acc1 [4];
    logic signed [A1W-1:0] sh1  [4];
    logic signed [TW-1:0]  n_t  [4];
    logic signed [TW-1:0]  r_t  [4];

    always_comb begin
        acc1[0] = A1W'(r_p1[0][0]) + A1W'(r_p1[0][1]) + A1W'(r_p1[0][2]) + RND1;
        acc1[1] = A1W'(r_p1[1][0]) - A1W'(r_p1[1][1]) + A1W'(r_p1[1][2]) + RND1;
        acc1[2] = A1W'(r_p1[2][0]) + A1W'(r_p1[2][1]) - A1W'(r_p1[2][2]) + RND1;
        acc1[3] = A1W'(r_p1[3][0]) + A1W'(r_p1[3][1]) - A1W'(r_p1[3][2]) + RND1;
        for (int r = 0; r < 4; r++) begin
            sh1[r] = acc1[r] >>> FRAC_BITS;
            if ((&sh1[r][A1W-1:TW-1]) || !(|sh1[r][A1W-1:TW-1])) begin
                n_t[r] = sh1[r][TW-1:0];
            end else begin
                n_t[r] = {sh1[r][A1W-1], {(TW-1){~sh1[r][A1W-1]}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[1]) begin
            r_t <= n_t;
        end
    end

    // Stage 3: the twelve products of q * t, rows out_x, out_y, out_z.
    logic signed [P2W-1:0] r_p2 [3][4];
    logic signed [P2W-1:0] n_p2 [3][4];

    always_comb begin
        n_p2[0][0] = P2W'(r_rot_w) * P2W'(r_t[1]);
        n_p2[0][1] = P2W'(r_rot_x) * P2W'(r_t[0]);
        n_p2[0][2] = P2W'(r_rot_y) * P2W'(r_t[3]);
        n_p2[0][3] = P2W'(r_rot_z) * P2W'(r_t[2]);
        n_p2[1][0] = P2W'(r_rot_w) * P2W'(r_t[2]);
        n_p2[1][1] = P2W'(r_rot_x) * P2W'(r_t[3]);
        n_p2[1][2] = P2W'(r_rot_y) * P2W'(r_t[0]);
        n_p2[1][3] = P2W'(r_rot_z) * P2W'(r_t[1]);
        n_p2[2][0] = P2W'(r_rot_w) * P2W'(r_t[3]);
        n_p2[2][1] = P2W'(r_rot_x) * P2W'(r_t[2]);
        n_p2[2][2] = P2W'(r_rot_y) * P2W'(r_t[1]);
        n_p2[2][3] = P2W'(r_rot_z) * P2W'(r_t[0]);
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[2]) begin
            r_p2 <= n_p2;
        end
    end

    // Stage 4: sum each row, round and saturate into the output register.
    logic signed [A2W-1:0] acc2  [3];
    logic signed [A2W-1:0] sh2   [3];
    logic signed [DW-1:0]  n_out [3];
    logic signed [DW-1:0]  r_out [3];

    always_comb begin
        acc2[0] = A2W'(r_p2[0][0]) + A2W'(r_p2[0][1]) + A2W'(r_p2[0][2])
                - A2W'(r_p2[0][3]) + RND2;
        acc2[1] = A2W'(r_p2[1][0]) - A2W'(r_p2[1][1]) + A2W'(r_p2[1][2])
                + A2W'(r_p2[1][3]) + RND2;
        acc2[2] = A2W'(r_p2[2][0]) + A2W'(r_p2[2][1]) - A2W'(r_p2[2][2])
                + A2W'(r_p2[2][3]) + RND2;
        for (int r = 0; r < 3; r++) begin
            sh2[r] = acc2[r] >>> FRAC_BITS;
            if ((&sh2[r][A2W-1:DW-1]) || !(|sh2[r][A2W-1:DW-1])) begin
                n_out[r] = sh2[r][DW-1:0];
            end else begin
                n_out[r] = {sh2[r][A2W-1], {(DW-1){~sh2[r][A2W-1]}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[3]) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid = r_vld[NSTG-1];
    assign o_res.out_x = r_out[0];
    assign o_res.out_y = r_out[1];
    assign o_res.out_z = r_out[2];

    // Pipeline checks.
    `QVR_ASSERT(a_accept_fills_first, (i_vec.valid && i_vec.ready) |=> r_vld[0], "accepted item not held in first stage")
    `QVR_ASSERT(a_empty_first_ready, !r_vld[0] |-> i_vec.ready, "input stalled with an empty first stage")
    `QVR_ASSERT(a_blocked_item_kept, (r_vld[2] && !stg_en[3]) |=> r_vld[2], "item lost behind a stalled output")
    `QVR_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> (r_vld == '0), "pipeline not empty after reset")

endmodule

`default_nettype wire
